@@ rtl/bpfl_pkg.sv @@
// Shared constants for the buffer pool free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpfl_pkg;

    localparam int ADDR_W   = 32;
    localparam int CAP_W    = 17;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 8;

    // serial divider: one quotient bit per step
    localparam int DIV_STEPS = ADDR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_START = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_BUF_CAP   = 1'b1;

    localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'd65536;
    localparam logic [CAP_W-1:0]  BUF_CAP_RST   = 17'd1024;

endpackage

`default_nettype wire

@@ rtl/buffer_pool_free_list_allocator_core.sv @@
// Buffer pool allocator: linked free list in a synchronous RAM, serial release divider.
`timescale 1ns / 1ps
`default_nettype none

// Hands out and takes back fixed-size buffers of a pool that grows in blocks
// of BLOCK_SIZE buffers up to MAX_BLOCKS. The free list lives in a simple
// dual-port synchronous RAM of next links. One item is worked at a time; a
// finished result sits in the output register so the next item can be taken
// while it waits. An allocate item passes S_MUL (index times buffer capacity)
// and S_ADDR; one from the free list first passes S_ALLOC_RD for the link
// read. A release item passes S_MUL and S_CHECK, then the restoring divider
// that finds the buffer index one quotient bit per cycle over the 32-bit
// address offset, then S_FIN; a null release goes straight to the output,
// and a release outside the enabled blocks leaves after S_CHECK. The link
// RAM needs no clearing after reset: a link is read only after its buffer
// was released.
module buffer_pool_free_list_allocator_core
    import bpfl_pkg::*;
#(
    parameter int BLOCK_SIZE = 16,
    parameter int MAX_BLOCKS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [31:0]         s_tdata,   // [31:0] address
    input  wire logic [0:0]          s_tuser,   // [0] req_type

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,   // [31:0] buffer_address, [39:32] buffer_index
    output logic [2:0]               m_tuser,   // [2:0] status

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    localparam int POOL_SLOTS = BLOCK_SIZE * MAX_BLOCKS;
    localparam int SLOT_W     = $clog2(POOL_SLOTS + 1);
    localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W     = SLOT_W + CAP_W;
    localparam int CMP_W      = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    localparam logic [SLOT_W-1:0] EMPTY_CODE = SLOT_W'(POOL_SLOTS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ALLOC_RD = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_ADDR     = 4'd3;
    localparam logic [3:0] S_CHECK    = 4'd4;
    localparam logic [3:0] S_DIV      = 4'd5;
    localparam logic [3:0] S_FIN      = 4'd6;
    localparam logic [3:0] S_OUT      = 4'd7;

    logic [3:0]           state_reg, state_next;
    logic [ADDR_W-1:0]    pool_base_reg, pool_base_next;
    logic [CAP_W-1:0]     buf_cap_reg, buf_cap_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [SLOT_W-1:0]    fresh_reg, fresh_next;
    logic [BLK_W-1:0]     blocks_reg, blocks_next;
    logic                 req_reg, req_next;
    logic [SLOT_W-1:0]    mul_a_reg, mul_a_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [ADDR_W-1:0]    offset_reg, offset_next;
    logic [ADDR_W-1:0]    quo_reg, quo_next;
    logic [CAP_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [INDEX_W-1:0]   res_index_reg, res_index_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [ADDR_W-1:0]    m_addr_reg;
    logic [INDEX_W-1:0]   m_index_reg;

    // link RAM
    logic [SLOT_W-1:0]    next_index_mem [POOL_SLOTS];
    logic [SLOT_W-1:0]    rd_data_reg;
    logic                 mem_re, mem_we;
    logic [IDX_W-1:0]     mem_raddr, mem_waddr;

    logic [SLOT_W-1:0]    en_slots;
    logic                 head_avail;
    logic [CAP_W+1:0]     div_shift;
    logic [CAP_W+1:0]     div_diff;
    logic                 out_load;

    assign en_slots   = SLOT_W'(blocks_reg * BLOCK_SIZE);
    assign head_avail = (head_reg < EMPTY_CODE);
    assign div_shift  = {1'b0, rem_reg, quo_reg[ADDR_W-1]};
    assign div_diff   = div_shift - {2'b00, buf_cap_reg};

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_index_reg, m_addr_reg};
    assign m_tuser   = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        pool_base_next  = pool_base_reg;
        buf_cap_next    = buf_cap_reg;
        head_next       = head_reg;
        fresh_next      = fresh_reg;
        blocks_next     = blocks_reg;
        req_next        = req_reg;
        mul_a_next      = mul_a_reg;
        prod_next       = prod_reg;
        offset_next     = offset_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_index_next  = res_index_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_raddr       = head_reg[IDX_W-1:0];
        mem_waddr       = quo_reg[IDX_W-1:0];
        out_load        = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index[0])
                REG_POOL_BASE: pool_base_next = cfg_data;
                REG_BUF_CAP:   buf_cap_next   = cfg_data[CAP_W-1:0];
                default:       pool_base_next = pool_base_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tuser[0];
                    if (s_tuser[0] == REQ_ALLOC) begin
                        if (head_avail) begin
                            // pop: fetch the link of the head
                            mem_re     = 1'b1;
                            mul_a_next = head_reg;
                            state_next = S_ALLOC_RD;
                        end else if (fresh_reg >= en_slots &&
                                     blocks_reg >= BLK_W'(MAX_BLOCKS)) begin
                            res_status_next = ST_EXHAUSTED;
                            res_addr_next   = '0;
                            res_index_next  = '0;
                            state_next      = S_OUT;
                        end else begin
                            if (fresh_reg >= en_slots) begin
                                blocks_next = blocks_reg + 1'b1;
                            end
                            mul_a_next = fresh_reg;
                            fresh_next = fresh_reg + 1'b1;
                            state_next = S_MUL;
                        end
                    end else begin
                        if (s_tdata == '0) begin
                            res_status_next = ST_NULL;
                            res_addr_next   = '0;
                            res_index_next  = '0;
                            state_next      = S_OUT;
                        end else begin
                            offset_next = s_tdata - pool_base_reg;
                            mul_a_next  = en_slots;
                            state_next  = S_MUL;
                        end
                    end
                end
            end
            S_ALLOC_RD: begin
                head_next  = rd_data_reg;
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = PROD_W'(mul_a_reg) * PROD_W'(buf_cap_reg);
                state_next = (req_reg == REQ_RELEASE) ? S_CHECK : S_ADDR;
            end
            S_ADDR: begin
                res_status_next = ST_OK;
                res_addr_next   = pool_base_reg + ADDR_W'(prod_reg);
                res_index_next  = INDEX_W'(mul_a_reg);
                state_next      = S_OUT;
            end
            S_CHECK: begin
                // prod holds the enabled span in bytes
                if (CMP_W'(offset_reg) >= CMP_W'(prod_reg)) begin
                    res_status_next = ST_OUTSIDE;
                    res_addr_next   = '0;
                    res_index_next  = '0;
                    state_next      = S_OUT;
                end else begin
                    quo_next   = offset_reg;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(DIV_STEPS);
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!div_diff[CAP_W+1]) begin
                    rem_next = div_diff[CAP_W-1:0];
                    quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
                end else begin
                    rem_next = div_shift[CAP_W-1:0];
                    quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                res_addr_next = '0;
                if (rem_reg != '0) begin
                    res_status_next = ST_NOT_START;
                    res_index_next  = '0;
                end else if (quo_reg >= ADDR_W'(POOL_SLOTS)) begin
                    res_status_next = ST_OUTSIDE;
                    res_index_next  = '0;
                end else begin
                    // push: link to the old head, become the head
                    mem_we          = 1'b1;
                    head_next       = SLOT_W'(quo_reg);
                    res_status_next = ST_OK;
                    res_index_next  = INDEX_W'(quo_reg);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pool_base_reg <= POOL_BASE_RST;
            buf_cap_reg   <= BUF_CAP_RST;
            head_reg      <= EMPTY_CODE;
            fresh_reg     <= '0;
            blocks_reg    <= BLK_W'(1);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pool_base_reg <= pool_base_next;
            buf_cap_reg   <= buf_cap_next;
            head_reg      <= head_next;
            fresh_reg     <= fresh_next;
            blocks_reg    <= blocks_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        mul_a_reg      <= mul_a_next;
        prod_reg       <= prod_next;
        offset_reg     <= offset_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_index_reg  <= res_index_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
            m_index_reg  <= res_index_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            next_index_mem[mem_waddr] <= head_reg;
        end
        if (mem_re) begin
            rd_data_reg <= next_index_mem[mem_raddr];
        end
    end

    // head is a real index or the empty code
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= EMPTY_CODE)
        else $error("free list head out of range");

    // fresh indices never run past the enabled blocks
    a_fresh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= en_slots && blocks_reg >= BLK_W'(1) &&
        blocks_reg <= BLK_W'(MAX_BLOCKS))
        else $error("fresh mark or block count out of range");

    // a link write only ever targets a pool slot
    a_push_index: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> quo_reg < ADDR_W'(POOL_SLOTS))
        else $error("link write beyond pool");

    // the divider never runs with an exhausted step count
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> cnt_reg != '0)
        else $error("divider step count underflow");

    // a popped head takes its link on the next cycle
    a_pop_link: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ALLOC_RD |=> head_reg == $past(rd_data_reg))
        else $error("free list pop lost its link");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the buffer pool free-list allocator core.
`timescale 1ns / 1ps

module tb;
    import bpfl_pkg::*;

    localparam int BLOCK_SIZE     = 16;
    localparam int MAX_BLOCKS     = 16;
    localparam int SLOTS          = BLOCK_SIZE * MAX_BLOCKS;
    localparam logic [8:0] LIST_EMPTY = 9'(SLOTS);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF       = 300;

    typedef struct packed {
        logic              rel;
        logic [ADDR_W-1:0] addr;
    } pool_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [INDEX_W-1:0]  idx;
    } grant_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;   // [31:0] address
    logic [0:0]  s_tuser   = '0;   // [0] req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [31:0] buffer_address, [39:32] buffer_index
    logic [2:0]  m_tuser;          // [2:0] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // shadow of the allocator
    logic [ADDR_W-1:0] base_reg = POOL_BASE_RST;
    logic [CAP_W-1:0]  cap_reg  = BUF_CAP_RST;
    logic [8:0]        free_head  = LIST_EMPTY;
    logic [8:0]        link_mem [SLOTS];
    logic [8:0]        fresh_mark = '0;
    logic [4:0]        blocks_on  = 5'd1;

    pool_req_t pending_reqs[$];
    grant_t    expected_grants[$];
    int        held_idx[$];

    int items_in       = 0;
    int results_seen   = 0;
    int exhausted_seen = 0;
    int errors         = 0;
    int quiet          = 0;
    int stall_left     = 0;
    bit held_off       = 0;
    wire steady = items_in >= 150 && items_in < 260;

    buffer_pool_free_list_allocator_core #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [ADDR_W-1:0] slot_addr(input int k);
        return base_reg + 32'(k) * 32'(cap_reg);
    endfunction

    // Apply one request to the shadow state and return the grant it yields.
    function automatic grant_t predict_grant(input logic rel, input logic [ADDR_W-1:0] a);
        grant_t      g;
        logic [8:0]  slot;
        logic [31:0] offset;
        logic [31:0] quo;
        logic [63:0] span;
        g = '{status: ST_OK, addr: '0, idx: '0};
        if (rel == REQ_ALLOC) begin
            if (free_head < LIST_EMPTY) begin
                slot = free_head;
                free_head = link_mem[slot[7:0]];
            end else begin
                if (32'(fresh_mark) >= 32'(blocks_on) * BLOCK_SIZE) begin
                    if (32'(blocks_on) >= MAX_BLOCKS) begin
                        g.status = ST_EXHAUSTED;
                        exhausted_seen++;
                        return g;
                    end
                    blocks_on++;
                end
                slot = fresh_mark;
                fresh_mark++;
            end
            g.addr = slot_addr(int'(slot));
            g.idx  = slot[7:0];
            held_idx.insert(held_idx.size(), int'(slot));
            return g;
        end
        if (a == '0) begin
            g.status = ST_NULL;
            return g;
        end
        offset = a - base_reg;
        span   = 64'(blocks_on) * 64'(BLOCK_SIZE) * 64'(cap_reg);
        if (64'(offset) >= span) begin
            g.status = ST_OUTSIDE;
            return g;
        end
        // span is nonzero here, so the capacity is too
        if (offset % 32'(cap_reg) != 0) begin
            g.status = ST_NOT_START;
            return g;
        end
        quo = offset / 32'(cap_reg);
        if (quo >= SLOTS) begin
            g.status = ST_OUTSIDE;
            return g;
        end
        link_mem[quo[7:0]] = free_head;
        free_head = quo[8:0];
        g.idx = quo[7:0];
        return g;
    endfunction

    // Request driver: present queued items, predict each accepted one.
    always @(posedge aclk) begin : req_driver
        pool_req_t nxt;
        logic      offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_grants.insert(expected_grants.size(),
                                       predict_grant(s_tuser[0], s_tdata));
                items_in++;
            end
            if (!s_tvalid || s_tready) begin
                offer = pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 33);
                if (offer) begin
                    nxt = pending_reqs.pop_front();
                    s_tdata <= nxt.addr;
                    s_tuser <= nxt.rel;
                end
                s_tvalid <= offer;
            end
        end
    end

    // Grant monitor: check each accepted result, drive ready with stalls.
    always @(posedge aclk) begin : grant_monitor
        grant_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_grants.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result status=%0d addr=%h idx=%0d",
                                 $realtime, m_tuser, m_tdata[31:0], m_tdata[39:32]);
                end else begin
                    want = expected_grants.pop_front();
                    if (m_tuser !== want.status || m_tdata[31:0] !== want.addr ||
                        m_tdata[39:32] !== want.idx) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: expected status=%0d addr=%h idx=%0d, got %0d %h %0d",
                                     $realtime, want.status, want.addr, want.idx,
                                     m_tuser, m_tdata[31:0], m_tdata[39:32]);
                    end
                end
            end
            // one long hold-off while requests keep coming, so the input backs up
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (!held_off && results_seen >= 30 && pending_reqs.size() >= 4) begin
                held_off   <= 1'b1;
                stall_left <= HOLD_OFF;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= steady || $urandom_range(99) >= 33;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input logic [0:0] which, input logic [31:0] val);
        @(posedge aclk);
        cfg_index <= which;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (which == REG_POOL_BASE)
            base_reg = val;
        else
            cap_reg = val[CAP_W-1:0];
    endtask

    // Put random data in the bits above the capacity field.
    task automatic write_cap(input int cap);
        write_reg(REG_BUF_CAP, ($urandom() & 32'hFFFE_0000) | 32'(cap));
    endtask

    task automatic queue_alloc();
        pending_reqs.insert(pending_reqs.size(),
                            pool_req_t'{rel: REQ_ALLOC, addr: $urandom()});
    endtask

    task automatic queue_release(input logic [ADDR_W-1:0] a);
        pending_reqs.insert(pending_reqs.size(), pool_req_t'{rel: REQ_RELEASE, addr: a});
    endtask

    // Wait until every queued item is through and answered.
    task automatic settle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_grants.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic queue_random(input int alloc_pct);
        int r;
        int j;
        int live;
        r    = $urandom_range(99);
        live = int'(blocks_on) * BLOCK_SIZE;
        if (r < alloc_pct) begin
            queue_alloc();
            return;
        end
        r = $urandom_range(99);
        if (r < 55 && held_idx.size() != 0) begin
            j = $urandom_range(held_idx.size() - 1);
            queue_release(slot_addr(held_idx[j]));
            held_idx.delete(j);
        end else if (r < 70 || (r < 80 && cap_reg < 2)) begin
            queue_release(slot_addr($urandom_range(live + 3)));
        end else if (r < 80) begin
            queue_release(slot_addr($urandom_range(live - 1)) +
                          $urandom_range(int'(cap_reg) - 1, 1));
        end else if (r < 85) begin
            queue_release('0);
        end else if (r < 95) begin
            queue_release($urandom());
        end else begin
            queue_release(base_reg - $urandom_range(64, 1));
        end
    endtask

    task automatic random_phase(input int n, input int alloc_pct);
        int sent;
        int b;
        sent = 0;
        while (sent < n) begin
            b = $urandom_range(24, 8);
            repeat (b) queue_random(alloc_pct);
            sent += b;
            settle();
        end
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: null, wrapped and far addresses, list push and pop
        queue_release('0);
        queue_release(base_reg - 1);
        queue_release(32'hFFFF_FFFF);
        queue_alloc();
        queue_alloc();
        queue_release(base_reg + 1);
        queue_release(slot_addr(1));
        queue_release(slot_addr(0));
        queue_alloc();
        queue_alloc();
        queue_release(slot_addr(15));    // never handed out, still taken
        queue_release(slot_addr(16));    // block not enabled yet
        queue_alloc();
        queue_alloc();
        settle();

        // top base, capacity 65536: addresses wrap past zero
        write_reg(REG_POOL_BASE, 32'hFFFF_FFFF);
        write_cap(65536);
        queue_alloc();
        queue_release(slot_addr(3));
        queue_release(base_reg);
        queue_release(slot_addr(16));
        settle();

        // zero capacity: empty span, allocations land on the base
        write_reg(REG_POOL_BASE, 32'h0000_0001);
        write_cap(0);
        queue_alloc();
        queue_release(32'h0000_0001);
        queue_release('0);
        queue_alloc();
        settle();

        write_cap(1);
        random_phase(60, 65);

        write_reg(REG_POOL_BASE, $urandom() | 32'h1);
        write_cap($urandom_range(65536, 1));
        random_phase(60, 65);

        write_reg(REG_POOL_BASE, 32'hFFFF_FF00);
        write_cap(65536);
        random_phase(60, 60);

        write_reg(REG_POOL_BASE, $urandom() | 32'h1);
        write_cap(3);
        random_phase(60, 65);

        // grow the pool until it runs dry, then churn the full list
        write_reg(REG_POOL_BASE, $urandom() | 32'h1);
        write_cap($urandom_range(200, 1));
        while (exhausted_seen < 6 && items_in < 340) begin
            random_phase(20, 95);
        end
        random_phase(40, 50);

        settle();
        repeat (64) @(posedge aclk);
        if (errors == 0 && expected_grants.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/bpfl_pkg.sv
rtl/buffer_pool_free_list_allocator_core.sv
dv/tb.sv
